>>> rtl/sdre_pkg.sv
// Shared types and constants for the signed radix digit emitter.
`default_nettype none

package sdre_pkg;

    localparam int SYM_SLOTS       = 16;
    localparam int SYM_W           = 8;
    localparam int VALUE_W         = 32;
    localparam int COUNT_W         = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int DIGIT_W         = 4;
    localparam int DIG_SLOTS       = 32;
    localparam int DIG_IDX_W       = 5;
    localparam int ND_W            = 6;
    localparam int BITS_PER_STEP   = 8;
    localparam int STEPS_PER_DIGIT = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W          = 2;
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = 1;
    localparam int QCNT_W          = 2;

    localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYMBOLS_LOW  = 2'd0,
        REG_SYMBOLS_HIGH = 2'd1,
        REG_SYMBOL_COUNT = 2'd2
    } cfg_reg_t;

    typedef logic [SYM_SLOTS-1:0][SYM_W-1:0] sym_tab_t;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/signed_radix_digit_emitter_unit.sv
// Top level of the signed radix digit emitter: config registers and wiring.
// The digit engine divides the 32-bit magnitude by the radix, 8 bits/cycle, and
//   emits the sign and symbols only once every digit of a value is stored.
// The engine finishes one value before it takes the next; a two-entry queue takes
//   new values while the engine works.
// Reset: asynchronous, active low; symbols "0","1" and radix 2, queue and engine empty.
`default_nettype none

module signed_radix_digit_emitter_unit #(
    parameter int MAX_SYMBOLS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // input channel
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [sdre_pkg::VALUE_W-1:0]    value,
    // output channel, one transaction per character
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [sdre_pkg::SYM_W-1:0]                  symbol,
    output logic                                        last,
    // configuration writes
    input  wire logic                                   cfg_we,
    input  wire logic [sdre_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [sdre_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import sdre_pkg::*;

    logic [CFG_DATA_W-1:0]  symbols_low_reg;
    logic [CFG_DATA_W-1:0]  symbols_high_reg;
    logic [COUNT_W-1:0]     symbol_count_reg;
    sym_tab_t               sym_tab;

    logic                   push_valid;
    logic                   push_ready;
    entry_t                 push_data;
    logic                   q_valid;
    logic                   q_pop;
    entry_t                 q_data;

    // Configuration registers; writes to an unknown index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbols_low_reg  <= CFG_DATA_W'(64'h3130);
            symbols_high_reg <= '0;
            symbol_count_reg <= COUNT_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                REG_SYMBOL_COUNT: symbol_count_reg <= cfg_data[COUNT_W-1:0];
                default:          symbol_count_reg <= symbol_count_reg;
            endcase
        end
    end

    // Symbol 0 sits in the low byte of the low register.
    assign sym_tab = {symbols_high_reg, symbols_low_reg};

    // Front end: check the base, take sign and magnitude.
    sdre_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .sym_tab      (sym_tab),
        .symbol_count (symbol_count_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    // Hold pending values so the front keeps accepting while digits go out.
    sdre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    // Back end: divide out the digits, then emit sign and symbols.
    sdre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .sym_tab   (sym_tab),
        .radix     (symbol_count_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last)
    );

endmodule

`default_nettype wire

>>> rtl/sdre_front.sv
// Front end: accept values, check the symbol table, split sign and magnitude.
`default_nettype none

module sdre_front #(
    parameter int MAX_SYMBOLS = 16
) (
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [sdre_pkg::VALUE_W-1:0]    value,
    input  wire sdre_pkg::sym_tab_t                     sym_tab,
    input  wire logic [sdre_pkg::COUNT_W-1:0]           symbol_count,
    output logic                                        push_valid,
    input  wire logic                                   push_ready,
    output sdre_pkg::entry_t                            push_data
);
    import sdre_pkg::*;

    logic base_ok;

    // A base is usable when the count is in range, no symbol in use is a sign
    // character and no two symbols in use are equal.
    always_comb
    begin
        base_ok = (symbol_count >= COUNT_W'(2)) && (symbol_count <= COUNT_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (COUNT_W'(i) < symbol_count)
            begin
                if (sym_tab[i] == SIGN_PLUS || sym_tab[i] == SIGN_MINUS)
                begin
                    base_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if (COUNT_W'(j) < symbol_count && sym_tab[i] == sym_tab[j])
                    begin
                        base_ok = 1'b0;
                    end
                end
            end
        end
    end

    // Drop transactions that arrive with an unusable base.
    assign in_ready       = push_ready;
    assign push_valid     = in_valid && base_ok;
    assign push_data.neg  = value[VALUE_W-1];
    assign push_data.mag  = value[VALUE_W-1] ? (~value + 1'b1) : value;

endmodule

`default_nettype wire

>>> rtl/sdre_queue.sv
// Two-entry queue between the front end and the digit engine.
`default_nettype none

module sdre_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire sdre_pkg::entry_t   push_data,
    output logic                    pop_valid,
    input  wire logic               pop,
    output sdre_pkg::entry_t        pop_data
);
    import sdre_pkg::*;

    entry_t              slots [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sdre_back.sv
// Digit engine: divide by the radix eight bits a cycle, then emit symbols.
`default_nettype none

module sdre_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    output logic                                q_pop,
    input  wire sdre_pkg::entry_t               q_data,
    input  wire sdre_pkg::sym_tab_t             sym_tab,
    input  wire logic [sdre_pkg::COUNT_W-1:0]   radix,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [sdre_pkg::SYM_W-1:0]          symbol,
    output logic                                last
);
    import sdre_pkg::*;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [VALUE_W-1:0]     work_reg;
    logic [VALUE_W-1:0]     work_next;
    logic [DIGIT_W-1:0]     rem_reg;
    logic [DIGIT_W-1:0]     rem_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    logic [ND_W-1:0]        nd_reg;
    logic [ND_W-1:0]        nd_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [DIG_IDX_W-1:0]   emit_idx_reg;
    logic [DIG_IDX_W-1:0]   emit_idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SYM_W-1:0]       symbol_reg;
    logic [SYM_W-1:0]       symbol_next;
    logic                   last_reg;
    logic                   last_next;
    logic [DIGIT_W-1:0]     digit_mem [DIG_SLOTS];
    logic                   dig_we;
    logic                   out_free;
    logic [DIGIT_W-1:0]     rem_v;
    logic [BITS_PER_STEP-1:0] quo_v;
    logic [DIGIT_W:0]       trial;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

    // Restoring division, one quotient bit per step, eight steps per cycle.
    always_comb
    begin
        rem_v = rem_reg;
        quo_v = '0;
        trial = '0;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            trial = {rem_v, work_reg[VALUE_W-1-i]};
            if (trial >= radix)
            begin
                quo_v[BITS_PER_STEP-1-i] = 1'b1;
                rem_v = DIGIT_W'(trial - radix);
            end
            else
            begin
                rem_v = trial[DIGIT_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        nd_next        = nd_reg;
        neg_next       = neg_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        dig_we         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    work_next  = q_data.mag;
                    neg_next   = q_data.neg;
                    rem_next   = '0;
                    step_next  = '0;
                    nd_next    = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                work_next = {work_reg[VALUE_W-BITS_PER_STEP-1:0], quo_v};
                rem_next  = rem_v;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS_PER_DIGIT - 1))
                begin
                    // Digit complete: store it, restart the remainder.
                    dig_we   = 1'b1;
                    rem_next = '0;
                    nd_next  = nd_reg + 1'b1;
                    if (work_next == '0 || nd_reg == ND_W'(DIG_SLOTS - 1))
                    begin
                        emit_idx_next = nd_reg[DIG_IDX_W-1:0];
                        state_next    = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = SIGN_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = sym_tab[digit_mem[emit_idx_reg]];
                    last_next      = (emit_idx_reg == '0);
                    if (emit_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            nd_reg        <= '0;
            emit_idx_reg  <= '0;
            neg_reg       <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            nd_reg        <= nd_next;
            emit_idx_reg  <= emit_idx_next;
            neg_reg       <= neg_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        if (dig_we)
        begin
            digit_mem[nd_reg[DIG_IDX_W-1:0]] <= rem_v;
        end
    end

    a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= ND_W'(DIG_SLOTS))
        else $error("digit count beyond buffer");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> {1'b0, rem_reg} < radix)
        else $error("partial remainder not below radix");

    a_sign_only_negative: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SIGN |-> neg_reg)
        else $error("sign emitted for non-negative value");

    a_last_ends_value: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && emit_idx_reg == '0) |=>
            (state_reg == ST_IDLE && out_valid_reg && last_reg))
        else $error("final symbol did not close the value");

endmodule

`default_nettype wire
